// ===== rtl/lcdmt_pkg.sv =====
// shared types and timing constants for the lcd mode timing controller
package lcdmt_pkg;

    localparam int FRAME_W = 17;
    localparam int LCLK_W  = 10;
    localparam int RECIP_W = 16;

    localparam logic [FRAME_W-1:0] FRAME_CLOCKS = 17'd70224;
    localparam logic [FRAME_W-1:0] VBLANK_START = 17'd65664;
    localparam logic [8:0]         LINE_CLOCKS  = 9'd456;
    localparam int                 LINE_RECIP_I = 32'h0100_0000 / 456;
    localparam logic [RECIP_W-1:0] LINE_RECIP   = RECIP_W'(LINE_RECIP_I);
    localparam logic [LCLK_W-1:0]  OAM_END      = 10'd80;
    localparam logic [LCLK_W-1:0]  XFER_END     = 10'd252;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } t_lcd_mode;

    typedef struct packed {
        logic [8:0] elapsed_clocks;
        logic       lcd_on;
        logic [7:0] compare_line;
        logic       compare_irq_enable;
        logic       oam_irq_enable;
        logic       hblank_irq_enable;
    } t_in_word;

    typedef struct packed {
        logic [7:0] line;
        logic [1:0] mode;
        logic       coincidence;
        logic       vblank_irq;
        logic       status_irq;
        logic       draw_line_request;
        logic       blank_screen;
    } t_out_word;

endpackage

// ===== rtl/lcd_mode_timing_controller_core.sv =====
// lcd mode timing controller: frame/line clocks, mode sequencing and interrupts
//
//   channel | valid      | ready       | word
//   --------+------------+-------------+--------------
//   input   | i_in_valid | o_in_ready  | i_in_word
//   output  | o_out_valid| i_out_ready | o_out_word
//
// one word per cycle while the output is not stalled; each word passes the input register, then the result register
// the timing state updates as a word moves from the input register to the result register
// a stalled output holds its word; the input register then fills and holds one word until the output drains
// reset (synchronous, active low) clears both clocks, mode, coincidence and last drawn line
module lcd_mode_timing_controller_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lcdmt_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lcdmt_pkg::t_out_word o_out_word
);
    import lcdmt_pkg::*;

    logic                   r_in_valid;
    t_in_word               r_in;
    logic                   r_out_valid;
    t_out_word              r_out;

    logic [FRAME_W-1:0]     r_frame;
    logic [LCLK_W-1:0]      r_line_clk;
    t_lcd_mode              r_mode;
    logic                   r_coin;
    logic [7:0]             r_last_drawn;

    logic [FRAME_W-1:0]     n_frame;
    logic [LCLK_W-1:0]      n_line_clk;
    t_lcd_mode              n_mode;
    logic                   n_coin;
    logic [7:0]             n_last_drawn;
    t_out_word              n_out;

    logic                   advance;
    logic [8:0]             el;
    logic [FRAME_W-1:0]     fsum;
    logic                   wrap;
    logic [LCLK_W-1:0]      lc_base;
    logic [LCLK_W-1:0]      lsum;
    logic [FRAME_W+RECIP_W-1:0] prod;
    logic [7:0]             line;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_comb begin
        el      = (r_in.elapsed_clocks > LINE_CLOCKS) ? LINE_CLOCKS : r_in.elapsed_clocks;
        fsum    = r_frame + FRAME_W'(el);
        wrap    = (fsum >= FRAME_CLOCKS);
        n_frame = wrap ? (fsum - FRAME_CLOCKS) : fsum;
        lc_base = wrap ? n_frame[LCLK_W-1:0] : r_line_clk;
        prod    = FRAME_W'(n_frame) * LINE_RECIP;
        line    = prod[31:24];
        lsum    = lc_base + LCLK_W'(el);

        n_coin       = r_coin;
        n_mode       = r_mode;
        n_line_clk   = lc_base;
        n_last_drawn = r_last_drawn;
        n_out        = '0;
        n_out.line   = line;

        // coincidence only tracked while the display is on
        if (r_in.lcd_on) begin
            if (line == r_in.compare_line) begin
                if (!r_coin) begin
                    n_coin = 1'b1;
                    n_out.status_irq = r_in.compare_irq_enable;
                end
            end else begin
                n_coin = 1'b0;
            end
        end

        if (n_frame >= VBLANK_START) begin
            if (r_mode != MODE_VBLANK) begin
                n_mode = MODE_VBLANK;
                n_out.vblank_irq   = 1'b1;
                n_out.blank_screen = !r_in.lcd_on;
            end
        end else begin
            n_line_clk = (lsum >= LCLK_W'(LINE_CLOCKS)) ? (lsum - LCLK_W'(LINE_CLOCKS)) : lsum;
            priority if (n_line_clk <= OAM_END) begin
                if (r_mode != MODE_OAM) begin
                    n_mode = MODE_OAM;
                    if (r_in.oam_irq_enable) n_out.status_irq = 1'b1;
                end
            end else if (n_line_clk <= XFER_END) begin
                n_mode = MODE_XFER;
            end else begin
                if (r_mode != MODE_HBLANK) begin
                    if (r_in.lcd_on && (r_last_drawn != line)) begin
                        n_last_drawn = line;
                        n_out.draw_line_request = 1'b1;
                    end
                    n_mode = MODE_HBLANK;
                    if (r_in.hblank_irq_enable) n_out.status_irq = 1'b1;
                end
            end
        end

        n_out.mode        = n_mode;
        n_out.coincidence = n_coin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_frame      <= '0;
            r_line_clk   <= '0;
            r_mode       <= MODE_HBLANK;
            r_coin       <= 1'b0;
            r_last_drawn <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_frame      <= n_frame;
                r_line_clk   <= n_line_clk;
                r_mode       <= n_mode;
                r_coin       <= n_coin;
                r_last_drawn <= n_last_drawn;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_word;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef SYNTHESIS
    a_frame_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame < FRAME_CLOCKS) else $error("frame clock out of range");

    a_line_clk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_clk < LCLK_W'(LINE_CLOCKS)) else $error("line clock out of range");

    a_vblank_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.vblank_irq |-> o_out_word.mode == MODE_VBLANK)
        else $error("vblank interrupt outside vblank");

    a_draw_in_hblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.draw_line_request |-> o_out_word.mode == MODE_HBLANK)
        else $error("draw request outside hblank");

    a_blank_with_vblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.blank_screen |-> o_out_word.vblank_irq)
        else $error("blank screen without vblank entry");

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid) else $error("result register not filled");
`endif

endmodule

// ===== sim/lcdmt_timing_checker.sv =====
// checker for the lcd mode timing controller: predicts each status word and compares
`timescale 1ns / 1ps

module lcdmt_timing_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  lcdmt_pkg::t_in_word  i_in_word,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  lcdmt_pkg::t_out_word i_out_word,
    output int                   o_fail_count,
    output int                   o_pending
);
    import lcdmt_pkg::*;

    localparam int unsigned FRAME_LEN  = 70224;
    localparam int unsigned VBL_FIRST  = 65664;
    localparam int unsigned LINE_LEN   = 456;
    localparam int unsigned LINE_MUL   = 36792;   // 2^24 / 456, truncated
    localparam int unsigned OAM_LAST   = 80;
    localparam int unsigned XFER_LAST  = 252;

    // timing state as the block should hold it
    logic [16:0] frame_clk;
    logic [9:0]  line_clk;
    logic [7:0]  drawn_line;
    t_lcd_mode   lcd_mode;
    logic        coinc;

    t_out_word   expected_status_q[$];
    int          status_idx;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] status word %0d: %s", $time, status_idx, msg);
        o_fail_count++;
    endtask

    task automatic report_field(input string field, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
    endtask

    task automatic predict_timing_step(input t_in_word w, output t_out_word r);
        int unsigned adv;
        int unsigned fc;
        int unsigned lc;
        logic [47:0] prod;
        logic [7:0]  ln;
        adv = (w.elapsed_clocks > LINE_LEN) ? LINE_LEN : int'(w.elapsed_clocks);
        r   = '0;
        fc  = frame_clk + adv;
        if (fc >= FRAME_LEN) begin
            fc       = fc - FRAME_LEN;
            line_clk = fc[9:0];
        end
        frame_clk = fc[16:0];
        prod      = 48'(fc) * 48'(LINE_MUL);
        ln        = prod[31:24];

        // coincidence only tracks while the display is on
        if (w.lcd_on) begin
            if (ln == w.compare_line) begin
                if (!coinc) begin
                    coinc = 1'b1;
                    if (w.compare_irq_enable)
                        r.status_irq = 1'b1;
                end
            end else begin
                coinc = 1'b0;
            end
        end

        if (fc >= VBL_FIRST) begin
            // line clock stands still through vblank
            if (lcd_mode != MODE_VBLANK) begin
                lcd_mode     = MODE_VBLANK;
                r.vblank_irq = 1'b1;
                if (!w.lcd_on)
                    r.blank_screen = 1'b1;
            end
        end else begin
            lc = line_clk + adv;
            while (lc >= LINE_LEN)
                lc -= LINE_LEN;
            line_clk = lc[9:0];
            if (lc <= OAM_LAST) begin
                if (lcd_mode != MODE_OAM) begin
                    lcd_mode = MODE_OAM;
                    if (w.oam_irq_enable)
                        r.status_irq = 1'b1;
                end
            end else if (lc <= XFER_LAST) begin
                lcd_mode = MODE_XFER;
            end else if (lcd_mode != MODE_HBLANK) begin
                if (w.lcd_on && drawn_line != ln) begin
                    drawn_line          = ln;
                    r.draw_line_request = 1'b1;
                end
                lcd_mode = MODE_HBLANK;
                if (w.hblank_irq_enable)
                    r.status_irq = 1'b1;
            end
        end

        r.line        = ln;
        r.mode        = lcd_mode;
        r.coincidence = coinc;
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        t_out_word next_word;
        if (!i_rst_n) begin
            frame_clk  = '0;
            line_clk   = '0;
            drawn_line = '0;
            lcd_mode   = MODE_HBLANK;
            coinc      = 1'b0;
            status_idx = 0;
            expected_status_q.delete();
        end else begin
            // retire before predicting: a word cannot come out in the cycle it goes in
            if (i_out_valid && i_out_ready) begin
                if (expected_status_q.size() == 0) begin
                    report_mismatch("arrived with none expected");
                end else begin
                    want = expected_status_q.pop_front();
                    report_field("line", i_out_word.line, want.line);
                    report_field("mode", i_out_word.mode, want.mode);
                    report_field("coincidence", i_out_word.coincidence, want.coincidence);
                    report_field("vblank_irq", i_out_word.vblank_irq, want.vblank_irq);
                    report_field("status_irq", i_out_word.status_irq, want.status_irq);
                    report_field("draw_line_request", i_out_word.draw_line_request,
                                 want.draw_line_request);
                    report_field("blank_screen", i_out_word.blank_screen,
                                 want.blank_screen);
                end
                status_idx++;
            end
            if (i_in_valid && i_in_ready) begin
                predict_timing_step(i_in_word, next_word);
                expected_status_q.push_back(next_word);
            end
        end
        o_pending <= expected_status_q.size();
    end

endmodule

// ===== sim/tb_top.sv =====
// testbench top for the lcd mode timing controller: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_top;
    import lcdmt_pkg::*;

    localparam int RANDOM_WORDS = 1900;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int FRAME_LEN    = 70224;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_ready;
    t_out_word out_word;

    int        mismatches;
    int        pending;
    int        cycle_cnt = 0;

    // stimulus-side bookkeeping of the frame position, used only to aim the stimulus
    int        frame_pos = 0;
    int        frame_idx = 0;
    logic      lcd_hold  = 1'b1;
    logic [7:0] cmp_hold = 8'd0;
    bit        bursting  = 1'b0;

    always #2 clk = ~clk;

    lcd_mode_timing_controller_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    lcdmt_timing_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .o_fail_count (mismatches),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycle_cnt, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (bursting || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // called at a falling edge; returns at a falling edge after the word is taken
    task automatic send_word(input logic [8:0] elapsed, input logic on,
                             input logic [7:0] cmp, input logic [2:0] irq_en);
        int gap;
        in_valid                   = 1'b1;
        in_word.elapsed_clocks     = elapsed;
        in_word.lcd_on             = on;
        in_word.compare_line       = cmp;
        in_word.compare_irq_enable = irq_en[2];
        in_word.oam_irq_enable     = irq_en[1];
        in_word.hblank_irq_enable  = irq_en[0];
        do
            @(posedge clk);
        while (!in_ready);
        frame_pos += (elapsed > 9'd456) ? 456 : int'(elapsed);
        if (frame_pos >= FRAME_LEN) begin
            frame_pos -= FRAME_LEN;
            frame_idx++;
        end
        @(negedge clk);
        gap = gap_len();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // receiver: ready runs and stalls of random length, some long stretches with no stall
    initial begin
        int run_len;
        int stall_len;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 8);
            out_ready = 1'b1;
            repeat (run_len) @(negedge clk);
            stall_len = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3);
            out_ready = 1'b0;
            repeat (stall_len) @(negedge clk);
        end
    end

    initial begin
        int          r;
        logic [8:0]  elapsed;
        logic        on;
        logic [63:0] prod;

        in_valid = 1'b0;
        in_word  = '0;
        rst_n    = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // line 0 with compare 0: coincidence and oam entry fire together
        send_word(9'd0,   1'b1, 8'd0,   3'b111);
        send_word(9'd0,   1'b1, 8'd0,   3'b111);
        send_word(9'd80,  1'b1, 8'd0,   3'b111);
        send_word(9'd1,   1'b1, 8'd0,   3'b111);
        send_word(9'd171, 1'b1, 8'd0,   3'b111);
        // hblank on line 0 of the first frame: no draw request
        send_word(9'd1,   1'b1, 8'd0,   3'b111);
        send_word(9'd203, 1'b1, 8'd1,   3'b100);
        send_word(9'd511, 1'b1, 8'd255, 3'b010);
        send_word(9'd457, 1'b0, 8'd255, 3'b001);
        send_word(9'd300, 1'b1, 8'd3,   3'b000);
        send_word(9'd256, 1'b1, 8'd3,   3'b111);
        // hblank entry with the display off: interrupt, no drawing
        send_word(9'd200, 1'b0, 8'd4,   3'b001);
        send_word(9'd456, 1'b0, 8'd4,   3'b110);
        send_word(9'd255, 1'b1, 8'd5,   3'b101);
        send_word(9'd170, 1'b1, 8'd6,   3'b011);
        send_word(9'd456, 1'b1, 8'd7,   3'b111);
        send_word(9'd128, 1'b1, 8'd128, 3'b000);

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i % 150 == 0)
                bursting = ($urandom_range(0, 2) == 0);

            r = $urandom_range(0, 99);
            if (r < 5)
                elapsed = 9'd0;
            else if (r < 60)
                elapsed = 9'($urandom_range(1, 100));
            else if (r < 88)
                elapsed = 9'($urandom_range(101, 456));
            else if (r < 93)
                elapsed = 9'($urandom_range(440, 456));
            else
                elapsed = 9'($urandom_range(457, 511));

            if ($urandom_range(0, 59) == 0)
                lcd_hold = ($urandom_range(0, 9) < 8);
            on = lcd_hold;
            // every other frame, run into vblank with the display off
            if (frame_idx[0] && frame_pos >= 63000 && frame_pos < 67500)
                on = 1'b0;

            if ($urandom_range(0, 29) == 0) begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    prod     = 64'(frame_pos) * 64'd36792;
                    cmp_hold = 8'(prod[31:24] + $urandom_range(0, 2));
                end else if (r < 85) begin
                    cmp_hold = 8'($urandom_range(0, 153));
                end else begin
                    cmp_hold = 8'($urandom_range(0, 255));
                end
            end

            send_word(elapsed, on, cmp_hold, 3'($urandom_range(0, 7)));
        end
        in_valid = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lcdmt_pkg.sv
rtl/lcd_mode_timing_controller_core.sv
sim/lcdmt_timing_checker.sv
sim/tb_top.sv
